// ===== rtl/core/sfr_pkg.sv =====
`timescale 1ns / 1ps

package sfr_pkg;

	localparam int KIND_W   = 2;
	localparam int BYTE_W   = 8;
	localparam int POS_W    = 6;
	localparam int TICK_W   = 5;
	localparam int STUFF_W  = 7;
	localparam int CFG_IDX_W = 2;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_ARM  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BYTE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FLAG    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STUFF   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

	localparam logic [BYTE_W-1:0] FLAG_RESET    = 8'd126;
	localparam logic [BYTE_W-1:0] STUFF_RESET   = 8'd125;
	localparam logic [TICK_W-1:0] TIMEOUT_RESET = 5'd15;

	// Frame layout: header, length byte position, trailer.
	localparam int HEAD_BYTES = 5;
	localparam int TAIL_BYTES = 2;
	localparam int LENGTH_POS = 4;
	// Width that holds HEAD_BYTES + 255 + TAIL_BYTES + 127.
	localparam int NEED_W = 9;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_GET   = 2'd1,
		MODE_ERROR = 2'd2
	} mode_t;

	typedef struct packed {
		logic [BYTE_W-1:0] flag_byte;
		logic [BYTE_W-1:0] stuff_byte;
		logic [TICK_W-1:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic [POS_W-1:0]  position;
		logic              frame_last;
		logic              timed_out;
	} result_t;

endpackage

// ===== rtl/core/sfr_ifs.sv =====
`timescale 1ns / 1ps

interface sfr_item_if import sfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output kind, output rx_byte, input ready);
	modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface sfr_result_if import sfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic [POS_W-1:0]  position;
	logic              frame_last;
	logic              timed_out;

	modport source (output valid, output out_byte, output position, output frame_last,
		output timed_out, input ready);
	modport sink (input valid, input out_byte, input position, input frame_last,
		input timed_out, output ready);
endinterface

// ===== rtl/core/sfr_cfg.sv =====
`timescale 1ns / 1ps

module sfr_cfg import sfr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] index,
	input  logic [BYTE_W-1:0]    data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_byte     <= FLAG_RESET;
			cfg_q.stuff_byte    <= STUFF_RESET;
			cfg_q.timeout_ticks <= TIMEOUT_RESET;
		end else if (wr_en) begin
			unique case (index)
				CFG_FLAG:    cfg_q.flag_byte     <= data;
				CFG_STUFF:   cfg_q.stuff_byte    <= data;
				CFG_TIMEOUT: cfg_q.timeout_ticks <= data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/sfr_frame.sv =====
`timescale 1ns / 1ps

module sfr_frame import sfr_pkg::*; #(
	parameter int MAX_FRAME = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [KIND_W-1:0] kind,
	input  logic [BYTE_W-1:0] rx_byte,
	input  cfg_t              cfg,
	output logic              res_valid,
	output result_t           res
);

	localparam int CW   = $clog2(MAX_FRAME + 1);
	localparam int CMPW = (CW > NEED_W) ? CW : NEED_W;

	mode_t              mode_q, mode_d;
	logic [CW-1:0]      count_q, count_d;
	logic               pend_q, pend_d;
	logic [STUFF_W-1:0] stuff_q, stuff_d;
	logic [BYTE_W-1:0]  len_q, len_d;
	logic [TICK_W-1:0]  ticks_q, ticks_d;

	logic               accept_byte;
	logic [CW-1:0]      count_inc;
	logic [STUFF_W-1:0] stuff_new;
	logic [BYTE_W-1:0]  len_new;
	logic [CMPW-1:0]    need;
	logic               last;
	logic               expire;

	// Byte path: the frame-end check sees the updated length and stuff count.
	always_comb begin
		accept_byte = (mode_q == MODE_GET) &&
			!(count_q == '0 && rx_byte != cfg.flag_byte);
		count_inc = count_q + 1'b1;
		stuff_new = (rx_byte == cfg.stuff_byte && !pend_q) ? stuff_q + 1'b1 : stuff_q;
		len_new   = (count_q == CW'(LENGTH_POS)) ? rx_byte : len_q;
		need      = CMPW'(HEAD_BYTES + TAIL_BYTES) + CMPW'(len_new) + CMPW'(stuff_new);
		last      = (count_inc >= CW'(HEAD_BYTES)) &&
			(CMPW'(count_inc) >= need || count_inc >= CW'(MAX_FRAME));
		expire    = (mode_q == MODE_GET) && (ticks_q <= TICK_W'(1));
	end

	// Next state.
	always_comb begin
		mode_d  = mode_q;
		count_d = count_q;
		pend_d  = pend_q;
		stuff_d = stuff_q;
		len_d   = len_q;
		ticks_d = ticks_q;
		if (step) begin
			case (kind)
				KIND_ARM: begin
					mode_d  = MODE_GET;
					count_d = '0;
					pend_d  = 1'b0;
					stuff_d = '0;
					len_d   = '0;
					ticks_d = cfg.timeout_ticks;
				end
				KIND_BYTE: begin
					if (accept_byte) begin
						if (last) begin
							mode_d  = MODE_IDLE;
							count_d = '0;
							pend_d  = 1'b0;
							stuff_d = '0;
							len_d   = '0;
						end else begin
							count_d = count_inc;
							pend_d  = (rx_byte == cfg.stuff_byte) && !pend_q;
							stuff_d = stuff_new;
							len_d   = len_new;
						end
					end
				end
				KIND_TICK: begin
					unique case (mode_q)
						MODE_GET: begin
							if (expire) begin
								mode_d  = MODE_ERROR;
								ticks_d = '0;
							end else begin
								ticks_d = ticks_q - 1'b1;
							end
						end
						MODE_ERROR: begin
							mode_d  = MODE_IDLE;
							count_d = '0;
							pend_d  = 1'b0;
							stuff_d = '0;
							len_d   = '0;
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// Result of the current item.
	always_comb begin
		res_valid      = 1'b0;
		res.out_byte   = '0;
		res.position   = '0;
		res.frame_last = 1'b0;
		res.timed_out  = 1'b0;
		unique case (kind)
			KIND_BYTE: begin
				if (accept_byte) begin
					res_valid      = 1'b1;
					res.out_byte   = rx_byte;
					res.position   = POS_W'(count_q);
					res.frame_last = last;
				end
			end
			KIND_TICK: begin
				if (expire) begin
					res_valid     = 1'b1;
					res.timed_out = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
			stuff_q <= '0;
			len_q   <= '0;
			ticks_q <= '0;
		end else begin
			mode_q  <= mode_d;
			count_q <= count_d;
			pend_q  <= pend_d;
			stuff_q <= stuff_d;
			len_q   <= len_d;
			ticks_q <= ticks_d;
		end
	end

	// A completed frame is cleared, so a stored count never reaches the cap.
	a_count_below_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CW'(MAX_FRAME))
		else $error("frame byte count reached the frame cap");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE |-> (count_q == '0 && stuff_q == '0 && !pend_q))
		else $error("frame progress left over while idle");

	a_timeout_to_error: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_valid && res.timed_out) |=> (mode_q == MODE_ERROR && ticks_q == '0))
		else $error("timeout result without entering error");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_valid && res.frame_last) |=> (mode_q == MODE_IDLE))
		else $error("frame end did not return to idle");

endmodule

// ===== rtl/core/stuffed_frame_receiver_with_timeout.sv =====
`timescale 1ns / 1ps

// Channel  | Dir | Beat payload                                    | Handshake
// item     | in  | kind, rx_byte                                   | valid/ready
// result   | out | out_byte, position, frame_last, timed_out       | valid/ready
// cfg      | in  | cfg_wr_en, cfg_index, cfg_data                  | write enable only
//
// One item is taken per cycle unless the result side stalls: a beat sits in the input
// register; its result, if any, goes into the output register when the beat advances.
// Reset clears the frame state, the pipeline valids and loads the register defaults.
// A stalled result stalls the input register, which holds one more beat before
// item.ready drops; items without a result still need the output side free to advance.

module stuffed_frame_receiver_with_timeout import sfr_pkg::*; #(
	parameter int MAX_FRAME = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	sfr_item_if.sink             item,
	sfr_result_if.source         result,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data
);

	cfg_t              cfg;
	logic              valid_s1;
	logic [KIND_W-1:0] kind_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;
	logic              res_valid;
	result_t           res;
	logic              out_valid_q;
	result_t           out_res_q;

	sfr_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			kind_s1 <= item.kind;
			byte_s1 <= item.rx_byte;
		end
	end

	sfr_frame #(
		.MAX_FRAME (MAX_FRAME)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.kind      (kind_s1),
		.rx_byte   (byte_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_res_q <= res;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.out_byte   = out_res_q.out_byte;
	assign result.position   = out_res_q.position;
	assign result.frame_last = out_res_q.frame_last;
	assign result.timed_out  = out_res_q.timed_out;

endmodule
